FILE: design/windowed_velocity_estimator_defines.svh
// assertion macros for the windowed velocity estimator design
`ifndef WINDOWED_VELOCITY_ESTIMATOR_DEFINES_SVH
`define WINDOWED_VELOCITY_ESTIMATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define WVE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define WVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wve_pkg.sv
`timescale 1ns / 1ps

package wve_pkg;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    localparam logic [1:0] CFG_WINDOW_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_WINDOW_SPAN    = 2'd1;
    localparam logic [1:0] CFG_MIN_GAP        = 2'd2;

    localparam logic [4:0]  RST_WINDOW_ENTRIES = 5'd16;
    localparam logic [31:0] RST_WINDOW_SPAN    = 32'd100;
    localparam logic [15:0] RST_MIN_GAP        = 16'd1;

    // rpm = (dA / 360) / (dT / 60000) = dA * 500 / (3 * dT), rounded half away
    // numerator 2 * 500 * |dA| + 3 * dT, denominator 2 * 3 * dT
    localparam int NUM_W = 43;
    localparam int DEN_W = 35;
    localparam logic [9:0] ANGLE_SCALE = 10'd1000;
    localparam logic [1:0] ROUND_SCALE = 2'd3;
    localparam logic [2:0] DEN_SCALE   = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED0,
        ST_SEED1,
        ST_GAP,
        ST_EVC,
        ST_EVA_RD,
        ST_EVA,
        ST_PUSH,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: design/wve_ram.sv
`timescale 1ns / 1ps

module wve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/wve_div.sv
`timescale 1ns / 1ps

module wve_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wve_pkg::NUM_W-1:0]   num,
    input  logic [wve_pkg::DEN_W-1:0]   den,
    output logic [wve_pkg::NUM_W-1:0]   quot,
    output wve_pkg::div_status_t        status
);

    import wve_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[DEN_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign quot        = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: design/windowed_velocity_estimator.sv
// stop and ignored items go straight to ST_DONE; start first seeds two records
// a skipped sample stops at the gap check; an updating sample evicts by count and
// by age, pushes and runs the 43-step serial divider, then saturates the velocity
// one transaction in flight; the next is accepted once the result register is free
// reset: asynchronous active low, window empty, velocity zero, registers at defaults
`timescale 1ns / 1ps
`include "windowed_velocity_estimator_defines.svh"

module windowed_velocity_estimator #(
    parameter int RING_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // time_ms [31:0], angle_deg [63:32]
    input  logic [1:0]  s_axis_tuser,   // opcode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // velocity_rpm [31:0]
    output logic [1:0]  m_axis_tuser,   // updated [0], span_zero [1]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    import wve_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - IW){1'b0}}, base} + {1'b0, off};
        if (sum >= (CW + 1)'(RING_DEPTH))
        begin
            sum = sum - (CW + 1)'(RING_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     oldest_reg, oldest_next;
    logic [31:0]       velocity_reg, velocity_next;
    logic [4:0]        win_entries_reg;
    logic [31:0]       win_span_reg;
    logic [15:0]       min_gap_reg;
    logic              out_valid_reg, out_valid_next;

    logic [1:0]        op_reg, op_next;
    logic [31:0]       time_reg, time_next;
    logic [31:0]       ang_reg, ang_next;
    logic [31:0]       old_stamp_reg, old_stamp_next;
    logic [31:0]       old_angle_reg, old_angle_next;
    logic [32:0]       dang_reg, dang_next;
    logic [31:0]       dt_reg, dt_next;
    logic [32:0]       mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic              upd_reg, upd_next;
    logic              zs_reg, zs_next;
    logic [31:0]       out_vel_reg, out_vel_next;
    logic              out_upd_reg, out_upd_next;
    logic              out_zs_reg, out_zs_next;

    logic [CW-1:0]     limit;
    logic              in_accept;
    logic [31:0]       gap;
    logic [31:0]       age;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [31:0]       ram_wstamp;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [31:0]       stamp_rdata;
    logic [31:0]       angle_rdata;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [NUM_W-1:0]  div_quot;
    div_status_t       div_st;

    wve_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wstamp),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (stamp_rdata)
    );

    wve_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_angle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ang_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (angle_rdata)
    );

    wve_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quot   (div_quot),
        .status (div_st)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // zero acts as one, anything above the ring depth as the depth
    always_comb
    begin
        if (win_entries_reg == 5'd0)
        begin
            limit = CW'(1);
        end
        else if (32'(win_entries_reg) > 32'(RING_DEPTH))
        begin
            limit = CW'(RING_DEPTH);
        end
        else
        begin
            limit = CW'(win_entries_reg);
        end
    end

    assign gap     = time_reg - stamp_rdata;
    assign age     = time_reg - stamp_rdata;
    assign div_num = NUM_W'(mag_reg) * NUM_W'(ANGLE_SCALE) + NUM_W'(dt_reg) * NUM_W'(ROUND_SCALE);
    assign div_den = DEN_W'(dt_reg) * DEN_W'(DEN_SCALE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        velocity_next  = velocity_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        time_next      = time_reg;
        ang_next       = ang_reg;
        old_stamp_next = old_stamp_reg;
        old_angle_next = old_angle_reg;
        dang_next      = dang_reg;
        dt_next        = dt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        upd_next       = upd_reg;
        zs_next        = zs_reg;
        out_vel_next   = out_vel_reg;
        out_upd_next   = out_upd_reg;
        out_zs_next    = out_zs_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_of(oldest_reg, count_reg);
        ram_wstamp     = time_reg;
        ram_re         = 1'b0;
        ram_raddr      = oldest_reg;
        div_start      = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next   = s_axis_tuser;
                    time_next = s_axis_tdata[31:0];
                    ang_next  = s_axis_tdata[63:32];
                    upd_next  = 1'b0;
                    zs_next   = 1'b0;
                    state_next = ST_DONE;
                    if (s_axis_tuser == OP_START)
                    begin
                        count_next  = '0;
                        oldest_next = '0;
                        state_next  = ST_SEED0;
                    end
                    else if (s_axis_tuser == OP_STOP)
                    begin
                        count_next    = '0;
                        oldest_next   = '0;
                        velocity_next = '0;
                    end
                    else if (s_axis_tuser == OP_SAMPLE && count_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot_of(oldest_reg, count_reg - 1'b1);
                        state_next = ST_GAP;
                    end
                end
            end
            ST_SEED0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                count_next = CW'(1);
                state_next = ST_SEED1;
            end
            ST_SEED1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(1);
                ram_wstamp = time_reg + 32'(min_gap_reg);
                count_next = CW'(2);
                state_next = ST_DONE;
            end
            ST_GAP:
            begin
                // gap to the newest record read as signed
                if ($signed({gap[31], gap}) < $signed({17'd0, min_gap_reg}))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_EVC;
                end
            end
            ST_EVC:
            begin
                if (count_reg != '0 && count_reg >= limit)
                begin
                    oldest_next = slot_of(oldest_reg, CW'(1));
                    count_next  = count_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EVA_RD;
                end
            end
            ST_EVA_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = oldest_reg;
                    state_next = ST_EVA;
                end
            end
            ST_EVA:
            begin
                if (age > win_span_reg)
                begin
                    oldest_next = slot_of(oldest_reg, CW'(1));
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_EVA_RD;
                end
                else
                begin
                    old_stamp_next = stamp_rdata;
                    old_angle_next = angle_rdata;
                    state_next     = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
                upd_next   = 1'b1;
                dt_next    = time_reg - old_stamp_reg;
                dang_next  = {ang_reg[31], ang_reg} - {old_angle_reg[31], old_angle_reg};
                // an empty window means the new record is also the oldest
                if (count_reg == '0 || time_reg == old_stamp_reg)
                begin
                    zs_next    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                neg_next   = dang_reg[32];
                mag_next   = dang_reg[32] ? (33'd0 - dang_reg) : dang_reg;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_st.done)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (neg_reg)
                begin
                    if (div_quot > NUM_W'(32'h8000_0000))
                    begin
                        velocity_next = 32'h8000_0000;
                    end
                    else
                    begin
                        velocity_next = 32'd0 - div_quot[31:0];
                    end
                end
                else
                begin
                    if (div_quot > NUM_W'(32'h7FFF_FFFF))
                    begin
                        velocity_next = 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        velocity_next = div_quot[31:0];
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_vel_next   = velocity_reg;
                    out_upd_next   = upd_reg;
                    out_zs_next    = zs_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            oldest_reg      <= '0;
            velocity_reg    <= '0;
            out_valid_reg   <= 1'b0;
            win_entries_reg <= RST_WINDOW_ENTRIES;
            win_span_reg    <= RST_WINDOW_SPAN;
            min_gap_reg     <= RST_MIN_GAP;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            velocity_reg  <= velocity_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_WINDOW_ENTRIES: win_entries_reg <= cfg_wdata[4:0];
                    CFG_WINDOW_SPAN:    win_span_reg    <= cfg_wdata;
                    CFG_MIN_GAP:        min_gap_reg     <= cfg_wdata[15:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        time_reg      <= time_next;
        ang_reg       <= ang_next;
        old_stamp_reg <= old_stamp_next;
        old_angle_reg <= old_angle_next;
        dang_reg      <= dang_next;
        dt_reg        <= dt_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        upd_reg       <= upd_next;
        zs_reg        <= zs_next;
        out_vel_reg   <= out_vel_next;
        out_upd_reg   <= out_upd_next;
        out_zs_reg    <= out_zs_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_vel_reg;
    assign m_axis_tuser[0] = out_upd_reg;
    assign m_axis_tuser[1] = out_zs_reg;

    `WVE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(RING_DEPTH), "window count above ring depth")
    `WVE_ASSERT_NOW(a_div_done_state, div_st.done, state_reg == ST_DIV && op_reg == OP_SAMPLE, "divider finished outside its wait state")
    `WVE_ASSERT_NEXT(a_push_grows, state_reg == ST_PUSH, count_reg == $past(count_reg) + 1'b1 && count_reg != '0, "push did not add a record")
    `WVE_ASSERT_NEXT(a_stop_clears, in_accept && s_axis_tuser == OP_STOP, velocity_reg == '0 && count_reg == '0, "stop left window or velocity")
    `WVE_ASSERT_NEXT(a_vel_hold, state_reg != ST_SAT && !(in_accept && s_axis_tuser == OP_STOP), $stable(velocity_reg), "velocity changed outside its update")

endmodule
